// ===== hdl/mmpid_pkg.sv =====
// Types and constants shared by the multi-motor PID block.
package mmpid_pkg;

  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int GAIN_W         = 16;
  localparam int SMALL_W        = 12;
  localparam int MASK_W         = 4;
  localparam int MID_W          = 2;
  localparam int SPEED_W        = 16;
  localparam int ERR_W          = 17;
  localparam int SUM_W          = 32;
  localparam int DIF_W          = 18;
  localparam int MUL_A_W        = 33;
  localparam int MUL_B_W        = 17;
  localparam int PROD_W         = 50;
  localparam int ACC_W          = 50;
  localparam int ACC_SPLIT      = 25;
  localparam int SC_W           = 62;
  localparam int DRIVE_W        = 21;
  localparam int GAIN_FRAC_BITS = 12;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P    = 16'd4506;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I    = 16'd82;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D    = 16'd328;
  localparam logic [SMALL_W-1:0] RST_SCALE     = 12'd1000;
  localparam logic [SMALL_W-1:0] RST_DZ_OFFSET = 12'd300;
  localparam logic [SMALL_W-1:0] RST_DZ_THRESH = 12'd200;
  localparam logic [SMALL_W-1:0] RST_ZERO_BAND = 12'd100;
  localparam logic [MASK_W-1:0]  RST_ZB_MASK   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_SCALE,
    REG_DZ_OFFSET,
    REG_DZ_THRESH,
    REG_ZERO_BAND,
    REG_ZB_MASK
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SMALL_W-1:0] scale;
    logic [SMALL_W-1:0] dz_offset;
    logic [SMALL_W-1:0] dz_thresh;
    logic [SMALL_W-1:0] zero_band;
    logic [MASK_W-1:0]  zb_mask;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC_D,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD_HI,
    ST_ABS,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     state_upd;
    mul_sel_t mul;
    logic     acc_add;
    logic     sc_lo;
    logic     sc_hi;
    logic     mag_ld;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic id_ok;
    logic out_busy;
  } stat_t;

endpackage

// ===== hdl/mmpid_regs.sv =====
// Configuration register file.
module mmpid_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mmpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmpid_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output mmpid_pkg::cfg_t                    cfg
);

  mmpid_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= mmpid_pkg::RST_GAIN_P;
      cfg_r.gain_i    <= mmpid_pkg::RST_GAIN_I;
      cfg_r.gain_d    <= mmpid_pkg::RST_GAIN_D;
      cfg_r.scale     <= mmpid_pkg::RST_SCALE;
      cfg_r.dz_offset <= mmpid_pkg::RST_DZ_OFFSET;
      cfg_r.dz_thresh <= mmpid_pkg::RST_DZ_THRESH;
      cfg_r.zero_band <= mmpid_pkg::RST_ZERO_BAND;
      cfg_r.zb_mask   <= mmpid_pkg::RST_ZB_MASK;
    end else if (cfg_wr_en) begin
      case (mmpid_pkg::cfg_idx_t'(cfg_index))
        mmpid_pkg::REG_GAIN_P:    cfg_r.gain_p    <= cfg_wdata;
        mmpid_pkg::REG_GAIN_I:    cfg_r.gain_i    <= cfg_wdata;
        mmpid_pkg::REG_GAIN_D:    cfg_r.gain_d    <= cfg_wdata;
        mmpid_pkg::REG_SCALE:     cfg_r.scale     <= cfg_wdata[mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_DZ_OFFSET: cfg_r.dz_offset <= cfg_wdata[mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_DZ_THRESH: cfg_r.dz_thresh <= cfg_wdata[mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_ZERO_BAND: cfg_r.zero_band <= cfg_wdata[mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_ZB_MASK:   cfg_r.zb_mask   <= cfg_wdata[mmpid_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/mmpid_ctrl.sv =====
// Sequencing state machine for the PID datapath.
module mmpid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mmpid_pkg::stat_t  stat,
  output mmpid_pkg::cmd_t   cmd
);

  mmpid_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmpid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul       = mmpid_pkg::MUL_P;
    in_stall      = 1'b1;
    case (state_r)
      mmpid_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid && stat.id_ok) begin
          state_nxt = mmpid_pkg::ST_UPD;
        end
      end
      mmpid_pkg::ST_UPD: begin
        cmd.state_upd = 1'b1;
        state_nxt     = mmpid_pkg::ST_MUL_P;
      end
      mmpid_pkg::ST_MUL_P: begin
        cmd.mul   = mmpid_pkg::MUL_P;
        state_nxt = mmpid_pkg::ST_MUL_I;
      end
      mmpid_pkg::ST_MUL_I: begin
        cmd.mul     = mmpid_pkg::MUL_I;
        cmd.acc_add = 1'b1;
        state_nxt   = mmpid_pkg::ST_MUL_D;
      end
      mmpid_pkg::ST_MUL_D: begin
        cmd.mul     = mmpid_pkg::MUL_D;
        cmd.acc_add = 1'b1;
        state_nxt   = mmpid_pkg::ST_ACC_D;
      end
      mmpid_pkg::ST_ACC_D: begin
        cmd.acc_add = 1'b1;
        state_nxt   = mmpid_pkg::ST_MUL_LO;
      end
      mmpid_pkg::ST_MUL_LO: begin
        cmd.mul   = mmpid_pkg::MUL_LO;
        state_nxt = mmpid_pkg::ST_MUL_HI;
      end
      mmpid_pkg::ST_MUL_HI: begin
        cmd.mul   = mmpid_pkg::MUL_HI;
        cmd.sc_lo = 1'b1;
        state_nxt = mmpid_pkg::ST_ADD_HI;
      end
      mmpid_pkg::ST_ADD_HI: begin
        cmd.sc_hi = 1'b1;
        state_nxt = mmpid_pkg::ST_ABS;
      end
      mmpid_pkg::ST_ABS: begin
        cmd.mag_ld = 1'b1;
        state_nxt  = mmpid_pkg::ST_FIN;
      end
      mmpid_pkg::ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = mmpid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmpid_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mmpid_dp.sv =====
// PID datapath: per-motor state, shared multiplier, dead-zone shaping, output register.
module mmpid_dp #(
  parameter int MOTOR_COUNT     = 4,
  parameter int SPEED_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mmpid_pkg::cmd_t                       cmd,
  output mmpid_pkg::stat_t                      stat,
  input  mmpid_pkg::cfg_t                       cfg,
  input  logic [mmpid_pkg::MID_W-1:0]           in_motor_id,
  input  logic signed [mmpid_pkg::SPEED_W-1:0]  in_measured_speed,
  input  logic signed [mmpid_pkg::SPEED_W-1:0]  in_target_speed,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mmpid_pkg::DRIVE_W-1:0]  out_drive_value,
  output logic [mmpid_pkg::MID_W-1:0]           out_motor_index
);

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int SH    = mmpid_pkg::GAIN_FRAC_BITS + SPEED_FRAC_BITS;
  localparam int MAG_W = mmpid_pkg::SC_W - SH;
  localparam int ERR_W = mmpid_pkg::ERR_W;
  localparam int SUM_W = mmpid_pkg::SUM_W;
  localparam int DIF_W = mmpid_pkg::DIF_W;
  localparam int A_W   = mmpid_pkg::MUL_A_W;
  localparam int P_W   = mmpid_pkg::PROD_W;
  localparam int ACC_W = mmpid_pkg::ACC_W;
  localparam int SPL   = mmpid_pkg::ACC_SPLIT;
  localparam int SC_W  = mmpid_pkg::SC_W;
  localparam int DRV_W = mmpid_pkg::DRIVE_W;

  localparam logic [MAG_W:0] DRV_POS_MAX = (MAG_W+1)'((1 << (DRV_W-1)) - 1);
  localparam logic [MAG_W:0] DRV_NEG_MAG = (MAG_W+1)'(1 << (DRV_W-1));
  localparam logic [DRV_W-1:0] DRV_MAX   = DRV_W'((1 << (DRV_W-1)) - 1);
  localparam logic [DRV_W-1:0] DRV_MIN   = DRV_W'(1 << (DRV_W-1));

  logic [mmpid_pkg::MID_W-1:0]          mid_r;
  logic signed [mmpid_pkg::SPEED_W-1:0] meas_r, targ_r;
  logic signed [ERR_W-1:0]              e_r;
  logic signed [SUM_W-1:0]              s_r;
  logic signed [DIF_W-1:0]              d_r;
  logic signed [SUM_W-1:0]              sum_r  [MOTOR_COUNT];
  logic signed [ERR_W-1:0]              prev_r [MOTOR_COUNT];
  logic signed [A_W-1:0]                mul_a;
  logic signed [mmpid_pkg::MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]                prod_r;
  logic signed [ACC_W-1:0]              acc_r;
  logic signed [SC_W-1:0]               sc_r;
  logic [SC_W-1:0]                      sc_abs;
  logic [MAG_W-1:0]                     mag_r;
  logic                                 neg_r;
  logic [IDX_W-1:0]                     idx;
  logic signed [ERR_W-1:0]              e_new;
  logic signed [SUM_W:0]                s_wide;
  logic signed [SUM_W-1:0]              s_sat;
  logic signed [DIF_W-1:0]              d_new;
  logic                                 zb_hit;
  logic [MAG_W:0]                       mag2;
  logic [DRV_W-1:0]                     drive;
  logic                                 out_valid_r;
  logic [DRV_W-1:0]                     drive_r;
  logic [mmpid_pkg::MID_W-1:0]          oidx_r;

  assign idx = IDX_W'(mid_r);

  always_comb begin
    e_new  = ERR_W'(targ_r) - ERR_W'(meas_r);
    s_wide = (SUM_W+1)'(sum_r[idx]) + (SUM_W+1)'(e_new);
    if (s_wide[SUM_W] != s_wide[SUM_W-1]) begin
      s_sat = s_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      s_sat = s_wide[SUM_W-1:0];
    end
    d_new = DIF_W'(e_new) - DIF_W'(prev_r[idx]);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mid_r  <= in_motor_id;
      meas_r <= in_measured_speed;
      targ_r <= in_target_speed;
    end
    if (cmd.state_upd) begin
      e_r <= e_new;
      s_r <= s_sat;
      d_r <= d_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        sum_r[i]  <= '0;
        prev_r[i] <= '0;
      end
    end else if (cmd.state_upd) begin
      sum_r[idx]  <= s_sat;
      prev_r[idx] <= e_new;
    end
  end

  always_comb begin
    case (cmd.mul)
      mmpid_pkg::MUL_P: begin
        mul_a = A_W'(e_r);
        mul_b = {1'b0, cfg.gain_p};
      end
      mmpid_pkg::MUL_I: begin
        mul_a = A_W'(s_r);
        mul_b = {1'b0, cfg.gain_i};
      end
      mmpid_pkg::MUL_D: begin
        mul_a = A_W'(d_r);
        mul_b = {1'b0, cfg.gain_d};
      end
      mmpid_pkg::MUL_LO: begin
        mul_a = {{(A_W-SPL){1'b0}}, acc_r[SPL-1:0]};
        mul_b = {{(mmpid_pkg::MUL_B_W-mmpid_pkg::SMALL_W){1'b0}}, cfg.scale};
      end
      mmpid_pkg::MUL_HI: begin
        mul_a = A_W'($signed(acc_r[ACC_W-1:SPL]));
        mul_b = {{(mmpid_pkg::MUL_B_W-mmpid_pkg::SMALL_W){1'b0}}, cfg.scale};
      end
      default: begin
        mul_a = A_W'(e_r);
        mul_b = {1'b0, cfg.gain_p};
      end
    endcase
  end

  assign sc_abs = sc_r[SC_W-1] ? SC_W'(-sc_r) : SC_W'(sc_r);

  always_ff @(posedge clk) begin
    prod_r <= P_W'(mul_a * mul_b);
    if (cmd.state_upd) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.sc_lo) begin
      sc_r <= SC_W'(prod_r);
    end else if (cmd.sc_hi) begin
      sc_r <= sc_r + {prod_r[SC_W-SPL-1:0], {SPL{1'b0}}};
    end
    if (cmd.mag_ld) begin
      mag_r <= sc_abs[SC_W-1:SH];
      neg_r <= sc_r[SC_W-1];
    end
  end

  // zero band and dead-zone offset work on magnitude; sign applied last
  always_comb begin
    zb_hit = cfg.zb_mask[mid_r] && (mag_r < MAG_W'(cfg.zero_band));
    if (zb_hit) begin
      mag2 = '0;
    end else if (mag_r > MAG_W'(cfg.dz_thresh)) begin
      mag2 = (MAG_W+1)'(mag_r) + (MAG_W+1)'(cfg.dz_offset);
    end else begin
      mag2 = (MAG_W+1)'(mag_r);
    end
    if (neg_r) begin
      drive = (mag2 > DRV_NEG_MAG) ? DRV_MIN : DRV_W'(-mag2[DRV_W-1:0]);
    end else begin
      drive = (mag2 > DRV_POS_MAX) ? DRV_MAX : mag2[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      drive_r <= drive;
      oidx_r  <= mid_r;
    end
  end

  assign stat.id_ok    = (32'(in_motor_id) < MOTOR_COUNT);
  assign stat.out_busy = out_valid_r & out_stall;

  assign out_valid       = out_valid_r;
  assign out_drive_value = drive_r;
  assign out_motor_index = oidx_r;

endmodule

// ===== hdl/multi_motor_pid_with_deadzone.sv =====
// Top level of the multi-motor PID speed controller with dead-zone shaping.
// Each request carries a motor index and measured and target speeds; one drive
// value comes back per request whose motor index is below MOTOR_COUNT (others
// are taken and dropped). No new request is taken until the sequencer has loaded
// the previous result into the output register: one shared 33x17 multiplier
// forms the three gain products and the two halves of the output scaling one
// after the other, followed by the magnitude, zero-band, offset and saturation
// steps. A stalled result holds the sequencer in its last step until the output
// register frees up.
// The next request is taken as soon as the sequencer returns to idle, even if
// the previous result has not yet been taken.
module multi_motor_pid_with_deadzone #(
  parameter int MOTOR_COUNT     = 4,
  parameter int SPEED_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mmpid_pkg::MID_W-1:0]           in_motor_id,
  input  logic signed [mmpid_pkg::SPEED_W-1:0]  in_measured_speed,
  input  logic signed [mmpid_pkg::SPEED_W-1:0]  in_target_speed,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mmpid_pkg::DRIVE_W-1:0]  out_drive_value,
  output logic [mmpid_pkg::MID_W-1:0]           out_motor_index,
  input  logic                                  cfg_wr_en,
  input  logic [mmpid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmpid_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  mmpid_pkg::cfg_t  cfg;
  mmpid_pkg::cmd_t  cmd;
  mmpid_pkg::stat_t stat;

  mmpid_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mmpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmpid_dp #(
    .MOTOR_COUNT     (MOTOR_COUNT),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg               (cfg),
    .in_motor_id       (in_motor_id),
    .in_measured_speed (in_measured_speed),
    .in_target_speed   (in_target_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_value   (out_drive_value),
    .out_motor_index   (out_motor_index)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the multi-motor PID speed controller with dead-zone shaping.
`timescale 1ns / 100ps

module tb;

  localparam int MOTORS     = 4;
  localparam int SPEED_FRAC = 12;
  localparam int QUIET_MAX  = 3000;
  localparam longint SUM_HI   = 64'sd2147483647;
  localparam longint SUM_LO   = -64'sd2147483648;
  localparam longint DRIVE_HI = 64'sd1048575;
  localparam longint DRIVE_LO = -64'sd1048576;

  typedef struct {
    logic signed [mmpid_pkg::DRIVE_W-1:0] drive;
    logic [mmpid_pkg::MID_W-1:0]          mid;
  } drive_res_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic [mmpid_pkg::MID_W-1:0]           in_motor_id;
  logic signed [mmpid_pkg::SPEED_W-1:0]  in_measured_speed;
  logic signed [mmpid_pkg::SPEED_W-1:0]  in_target_speed;
  logic                                  out_valid;
  logic                                  out_stall;
  logic signed [mmpid_pkg::DRIVE_W-1:0]  out_drive_value;
  logic [mmpid_pkg::MID_W-1:0]           out_motor_index;
  logic                                  cfg_wr_en;
  logic [mmpid_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [mmpid_pkg::CFG_DATA_W-1:0]      cfg_wdata;

  mmpid_pkg::cfg_t                       cur_cfg;
  logic signed [mmpid_pkg::SUM_W-1:0]    sum_mem [MOTORS];
  logic signed [mmpid_pkg::ERR_W-1:0]    prev_mem [MOTORS];
  drive_res_t                            pending_drives [$];
  int                                    mismatch_count;
  int                                    send_idle_pct;
  int                                    stall_pct;
  int                                    hold_req;
  int                                    quiet_cycles;

  multi_motor_pid_with_deadzone #(
    .MOTOR_COUNT    (MOTORS),
    .SPEED_FRAC_BITS(SPEED_FRAC)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_motor_id      (in_motor_id),
    .in_measured_speed(in_measured_speed),
    .in_target_speed  (in_target_speed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive_value  (out_drive_value),
    .out_motor_index  (out_motor_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Updates the per-motor integrator and derivative history, queues the drive value.
  function automatic void predict_drive(input logic [mmpid_pkg::MID_W-1:0] mid,
                                        input logic signed [mmpid_pkg::SPEED_W-1:0] meas,
                                        input logic signed [mmpid_pkg::SPEED_W-1:0] tgt);
    longint err, tot, dif, acc, prod, mag, v, thr, off;
    drive_res_t res;
    err = longint'(tgt) - longint'(meas);
    tot = longint'(sum_mem[mid]) + err;
    if (tot > SUM_HI) tot = SUM_HI;
    if (tot < SUM_LO) tot = SUM_LO;
    sum_mem[mid] = tot[mmpid_pkg::SUM_W-1:0];
    dif = err - longint'(prev_mem[mid]);
    prev_mem[mid] = err[mmpid_pkg::ERR_W-1:0];
    acc = err * longint'({48'd0, cur_cfg.gain_p}) + tot * longint'({48'd0, cur_cfg.gain_i})
        + dif * longint'({48'd0, cur_cfg.gain_d});
    prod = acc * longint'({52'd0, cur_cfg.scale});
    mag = ((prod < 0) ? -prod : prod) >>> (mmpid_pkg::GAIN_FRAC_BITS + SPEED_FRAC);
    v = (prod < 0) ? -mag : mag;
    if (cur_cfg.zb_mask[mid] && mag < longint'({52'd0, cur_cfg.zero_band})) v = 0;
    thr = longint'({52'd0, cur_cfg.dz_thresh});
    off = longint'({52'd0, cur_cfg.dz_offset});
    if (v > thr) v = v + off;
    else if (v < -thr) v = v - off;
    if (v > DRIVE_HI) v = DRIVE_HI;
    if (v < DRIVE_LO) v = DRIVE_LO;
    res.drive = v[mmpid_pkg::DRIVE_W-1:0];
    res.mid   = mid;
    pending_drives.push_back(res);
  endfunction

  task automatic check_result();
    drive_res_t res;
    if (pending_drives.size() == 0) begin
      report_mismatch($sformatf("drive %0d for motor %0d with no request pending",
                                out_drive_value, out_motor_index));
    end else begin
      res = pending_drives.pop_front();
      if (out_drive_value !== res.drive) begin
        report_mismatch($sformatf("drive_value %0d, expected %0d (motor %0d)",
                                  out_drive_value, res.drive, res.mid));
      end
      if (out_motor_index !== res.mid) begin
        report_mismatch($sformatf("motor_index %0d, expected %0d",
                                  out_motor_index, res.mid));
      end
    end
  endtask

  // Result side: check at the rising edge, pick the next stall at the falling edge.
  initial begin
    int  hold_left;
    logic stall_nxt;
    hold_left = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        stall_nxt = 1'b1;
        hold_left--;
      end else begin
        stall_nxt = ($urandom_range(99) < stall_pct);
      end
      @(negedge clk);
      out_stall <= stall_nxt;
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_MAX);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [mmpid_pkg::MID_W-1:0] mid,
                              input logic signed [mmpid_pkg::SPEED_W-1:0] meas,
                              input logic signed [mmpid_pkg::SPEED_W-1:0] tgt);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_motor_id       <= mid;
    in_measured_speed <= meas;
    in_target_speed   <= tgt;
    do @(posedge clk); while (in_stall);
    predict_drive(mid, meas, tgt);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Writes every register in index order; upper data bits beyond a field are don't-care.
  task automatic write_regs(input logic [15:0] gp, input logic [15:0] gi,
                            input logic [15:0] gd, input logic [15:0] sc,
                            input logic [15:0] off, input logic [15:0] thr,
                            input logic [15:0] zb, input logic [15:0] msk);
    mmpid_pkg::cfg_idx_t r;
    logic [15:0]         v [8];
    v = '{gp, gi, gd, sc, off, thr, zb, msk};
    r = r.first();
    do begin
      cfg_wr_en <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= v[r];
      case (r)
        mmpid_pkg::REG_GAIN_P:    cur_cfg.gain_p    = v[r];
        mmpid_pkg::REG_GAIN_I:    cur_cfg.gain_i    = v[r];
        mmpid_pkg::REG_GAIN_D:    cur_cfg.gain_d    = v[r];
        mmpid_pkg::REG_SCALE:     cur_cfg.scale     = v[r][mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_DZ_OFFSET: cur_cfg.dz_offset = v[r][mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_DZ_THRESH: cur_cfg.dz_thresh = v[r][mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_ZERO_BAND: cur_cfg.zero_band = v[r][mmpid_pkg::SMALL_W-1:0];
        mmpid_pkg::REG_ZB_MASK:   cur_cfg.zb_mask   = v[r][mmpid_pkg::MASK_W-1:0];
        default: ;
      endcase
      @(negedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_reset_regs();
    write_regs(16'(mmpid_pkg::RST_GAIN_P), 16'(mmpid_pkg::RST_GAIN_I),
               16'(mmpid_pkg::RST_GAIN_D), 16'(mmpid_pkg::RST_SCALE),
               16'(mmpid_pkg::RST_DZ_OFFSET), 16'(mmpid_pkg::RST_DZ_THRESH),
               16'(mmpid_pkg::RST_ZERO_BAND), 16'(mmpid_pkg::RST_ZB_MASK));
  endtask

  function automatic logic [15:0] rand_word();
    return 16'($urandom_range(65535) >> $urandom_range(15));
  endfunction

  function automatic logic signed [mmpid_pkg::SPEED_W-1:0] edge_speed();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return mmpid_pkg::SPEED_W'($urandom);
    endcase
  endfunction

  // Reset gains: speed extremes, zero band on the masked motor, dead-zone edges.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_request(0, 0, 0);
    send_request(0, -32768, 32767);
    send_request(1, 32767, -32768);
    send_request(2, 32767, 32767);
    send_request(3, -32768, -32768);
    send_request(3, 0, 100);
    send_request(0, 0, 100);
    send_request(3, 0, -100);
    send_request(3, 0, 600);
    send_request(0, 0, 700);
    send_request(1, 0, 760);
    send_request(1, 0, -760);
    send_request(2, 0, -700);
    send_request(2, 1, 0);
    send_request(3, 32767, 0);
    send_request(3, -1, -1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_regs('1, '1, '1, '1, '1, 16'h0000, '1, '1);
    send_request(0, -32768, 32767);
    send_request(1, 32767, -32768);
    send_request(2, 0, 1);
    send_request(3, 0, -1);
    wait_idle();
    write_regs('0, '0, '0, '0, '0, '0, '0, '0);
    send_request(0, -32768, 32767);
    send_request(3, 32767, -32768);
    wait_idle();
    write_reset_regs();
  endtask

  // Integral gain only, so the output follows the error sum up and back down.
  task automatic test_integral_sum();
    write_regs(16'd0, 16'd256, 16'd0, 16'd4095, 16'd0, 16'd4095, 16'd0, 16'd0);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int n = 0; n < 20; n++) send_request(2, -32768, 32767);
    for (int n = 0; n < 10; n++) send_request(2, 100, -100);
    for (int n = 0; n < 20; n++) send_request(1, 32767, -32768);
    for (int n = 0; n < 10; n++) send_request(1, -100, 100);
    wait_idle();
    write_reset_regs();
  endtask

  task automatic test_random_phases();
    int                                    pick, delta, t;
    logic signed [mmpid_pkg::SPEED_W-1:0]  m_s, t_s;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      for (int k = 0; k < 2; k++) begin
        if (phase == 0 && k == 0) begin
          write_reset_regs();
        end else begin
          write_regs(rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), rand_word());
        end
        for (int n = 0; n < 165; n++) begin
          pick = $urandom_range(2);
          m_s  = mmpid_pkg::SPEED_W'($urandom);
          case (pick)
            0: t_s = mmpid_pkg::SPEED_W'($urandom);
            1: begin
              delta = (int'($urandom_range(4095)) - 2048) >>> $urandom_range(11);
              t = int'(m_s) + delta;
              if (t > 32767) t = 32767;
              if (t < -32768) t = -32768;
              t_s = t[mmpid_pkg::SPEED_W-1:0];
            end
            default: begin
              m_s = edge_speed();
              t_s = edge_speed();
            end
          endcase
          send_request(mmpid_pkg::MID_W'($urandom_range(MOTORS - 1)), m_s, t_s);
        end
        wait_idle();
      end
    end
  endtask

  // Long output hold-off while requests keep coming, so the input side backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 400;
    for (int n = 0; n < 40; n++) begin
      send_request(mmpid_pkg::MID_W'($urandom_range(MOTORS - 1)),
                   mmpid_pkg::SPEED_W'($urandom), mmpid_pkg::SPEED_W'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_motor_id       = '0;
    in_measured_speed = '0;
    in_target_speed   = '0;
    cfg_wr_en         = 1'b0;
    cfg_index         = mmpid_pkg::REG_GAIN_P;
    cfg_wdata         = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_req          = 0;
    quiet_cycles      = 0;
    mismatch_count    = 0;
    cur_cfg.gain_p    = mmpid_pkg::RST_GAIN_P;
    cur_cfg.gain_i    = mmpid_pkg::RST_GAIN_I;
    cur_cfg.gain_d    = mmpid_pkg::RST_GAIN_D;
    cur_cfg.scale     = mmpid_pkg::RST_SCALE;
    cur_cfg.dz_offset = mmpid_pkg::RST_DZ_OFFSET;
    cur_cfg.dz_thresh = mmpid_pkg::RST_DZ_THRESH;
    cur_cfg.zero_band = mmpid_pkg::RST_ZERO_BAND;
    cur_cfg.zb_mask   = mmpid_pkg::RST_ZB_MASK;
    for (int i = 0; i < MOTORS; i++) begin
      sum_mem[i]  = '0;
      prev_mem[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_integral_sum();
    test_random_phases();
    test_backpressure();

    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mmpid_pkg.sv
hdl/mmpid_regs.sv
hdl/mmpid_ctrl.sv
hdl/mmpid_dp.sv
hdl/multi_motor_pid_with_deadzone.sv
bench/tb.sv
